[rtl/core/cdt_pkg.sv]
// shared types and constants for the countdown timer with double press
package cdt_pkg;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_START = 2'd1,
		KIND_SET   = 2'd2,
		KIND_STEP  = 2'd3
	} kind_t;

	// configuration register indexes
	localparam logic [0:0] CFG_WINDOW = 1'b0;
	localparam logic [0:0] CFG_STEP   = 1'b1;

	localparam logic [15:0] WINDOW_RST = 16'd300;
	localparam logic [21:0] STEP_RST   = 22'd60000;

	localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;
	localparam logic [15:0] ALL16 = 16'hFFFF;

	typedef struct packed {
		logic [15:0] window;
		logic [21:0] step;
	} cfg_t;

	typedef struct packed {
		logic        running;
		logic        alarm;
		logic        setting;
		logic [31:0] time_left;
		logic [31:0] target_time;
		logic        press_pending;
	} res_t;

endpackage

[rtl/core/cdt_engine.sv]
// timer state registers and the per-event update logic
module cdt_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  cdt_pkg::kind_t kind,
	input  logic           clockwise,
	input  cdt_pkg::cfg_t  cfg,
	output cdt_pkg::res_t  result
);
	import cdt_pkg::*;

	logic [31:0] elapsed_q, elapsed_d;
	logic [31:0] target_q, target_d;
	logic        run_q, run_d;
	logic        alarm_q, alarm_d;
	logic        set_q, set_d;
	logic        wait_q, wait_d;
	logic [15:0] age_q, age_d;

	always_comb begin
		logic [31:0] el_inc;
		logic [15:0] age_inc;
		logic [32:0] sum;
		elapsed_d = elapsed_q;
		target_d  = target_q;
		run_d     = run_q;
		alarm_d   = alarm_q;
		set_d     = set_q;
		wait_d    = wait_q;
		age_d     = age_q;
		el_inc    = (elapsed_q != ALL32) ? elapsed_q + 32'd1 : elapsed_q;
		age_inc   = (age_q != ALL16) ? age_q + 16'd1 : age_q;
		sum       = {1'b0, target_q} + {11'd0, cfg.step};
		unique case (kind)
			KIND_TICK: begin
				if (run_q) begin
					elapsed_d = el_inc;
					// alarm check uses the advanced count
					if (!alarm_q && el_inc >= target_q) begin
						alarm_d = 1'b1;
						run_d   = 1'b0;
					end
				end
				if (wait_q) begin
					age_d = age_inc;
					if (age_inc >= cfg.window) begin
						// window closed: single press decision on updated flags
						wait_d = 1'b0;
						if (alarm_d) begin
							alarm_d = 1'b0;
						end else if (run_d) begin
							run_d = 1'b0;
						end else if (target_q != 32'd0 && !set_q) begin
							run_d = 1'b1;
						end
					end
				end
			end
			KIND_START: begin
				if (wait_q && age_q < cfg.window) begin
					wait_d    = 1'b0;
					run_d     = 1'b0;
					alarm_d   = 1'b0;
					set_d     = 1'b0;
					elapsed_d = '0;
				end else begin
					wait_d = 1'b1;
					age_d  = '0;
				end
			end
			KIND_SET: begin
				if (!run_q && !alarm_q) begin
					set_d = !set_q;
				end
			end
			KIND_STEP: begin
				if (set_q && !run_q && !alarm_q) begin
					if (clockwise) begin
						target_d = sum[32] ? ALL32 : sum[31:0];
					end else if (target_q >= {10'd0, cfg.step}) begin
						target_d = target_q - {10'd0, cfg.step};
					end
					elapsed_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			target_q  <= '0;
			run_q     <= 1'b0;
			alarm_q   <= 1'b0;
			set_q     <= 1'b0;
			wait_q    <= 1'b0;
			age_q     <= '0;
		end else if (advance) begin
			elapsed_q <= elapsed_d;
			target_q  <= target_d;
			run_q     <= run_d;
			alarm_q   <= alarm_d;
			set_q     <= set_d;
			wait_q    <= wait_d;
			age_q     <= age_d;
		end
	end

	always_comb begin
		result.running       = run_d;
		result.alarm         = alarm_d;
		result.setting       = set_d;
		result.time_left     = (elapsed_d >= target_d) ? 32'd0 : target_d - elapsed_d;
		result.target_time   = target_d;
		result.press_pending = wait_d;
	end

endmodule

[rtl/core/countdown_timer_with_double_press.sv]
// top level of the countdown timer with double-press start button
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_stall  | kind, clockwise
//  out     | out_valid/out_stall| running, alarm, setting, time_left,
//          |                    | target_time, press_pending
//  cfg     | cfg_wr_en          | cfg_index, cfg_wdata
//
// one transaction per cycle sustained while out_stall is low; an accepted input
// passes the input register, then the result register with the updated state
// reset clears all timer state and loads the register defaults, no clearing pass
// an out stall holds the result; in_stall rises only when the input register
// is full and the result register cannot drain
module countdown_timer_with_double_press (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic        clockwise,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        running,
	output logic        alarm,
	output logic        setting,
	output logic [31:0] time_left,
	output logic [31:0] target_time,
	output logic        press_pending,
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [21:0] cfg_wdata
);
	import cdt_pkg::*;

	cfg_t  cfg_q;
	logic  valid_s1;
	kind_t kind_s1;
	logic  cw_s1;
	logic  out_valid_q;
	res_t  res_q;
	res_t  res_d;
	logic  out_ready;
	logic  advance;

	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window <= WINDOW_RST;
			cfg_q.step   <= STEP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_WINDOW: cfg_q.window <= cfg_wdata[15:0];
				CFG_STEP:   cfg_q.step   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_ready) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind_t'(kind);
			cw_s1   <= clockwise;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	cdt_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.kind      (kind_s1),
		.clockwise (cw_s1),
		.cfg       (cfg_q),
		.result    (res_d)
	);

	assign out_valid     = out_valid_q;
	assign running       = res_q.running;
	assign alarm         = res_q.alarm;
	assign setting       = res_q.setting;
	assign time_left     = res_q.time_left;
	assign target_time   = res_q.target_time;
	assign press_pending = res_q.press_pending;

`ifndef SYNTH
	// alarm always stops the countdown
	a_run_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.running && res_q.alarm))
		else $error("running and alarm both set");

	// timer never starts while in set mode and set mode cannot open while running
	a_run_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.running && res_q.setting))
		else $error("running while in set mode");

	a_rem_le_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.time_left <= res_q.target_time))
		else $error("remaining exceeds target");

	// a held result must not be overwritten by the next transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(res_q))
		else $error("stalled result changed");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with room available");
`endif

endmodule

[verif/countdown_timer_with_double_press_test.sv]
// self-checking testbench for the countdown timer with double-press start button
`timescale 1ns / 1ps

module countdown_timer_with_double_press_test;
	import cdt_pkg::*;

	localparam int HOLD_CYCLES = 80;
	localparam int STUCK_LIMIT = 1000;
	localparam int RANDOM_PER_PHASE = 90;
	localparam int MAX_PRINTED = 40;

	typedef struct {
		kind_t kind;
		logic  cw;
	} timer_evt_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	kind_t       kind = KIND_TICK;
	logic        clockwise = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        running;
	logic        alarm;
	logic        setting;
	logic [31:0] time_left;
	logic [31:0] target_time;
	logic        press_pending;
	logic        cfg_wr_en = 1'b0;
	logic [0:0]  cfg_index = CFG_WINDOW;
	logic [21:0] cfg_wdata = '0;

	countdown_timer_with_double_press dut (.*);

	// predicted timer state and register copies
	logic [31:0] t_elapsed;
	logic [31:0] t_target;
	logic        t_run;
	logic        t_alarm;
	logic        t_set;
	logic        t_waiting;
	logic [15:0] t_age;
	logic [15:0] cfg_window;
	logic [21:0] cfg_step;

	timer_evt_t pending_events[$];
	res_t       status_due[$];

	int  send_gap = 0;
	int  stall_left = 0;
	int  idle_cycles = 0;
	bit  send_quiet = 1'b0;
	bit  rcv_quiet = 1'b0;
	bit  hold_request = 1'b0;
	int  mismatches = 0;
	int  results_checked = 0;
	int  alarms_raised = 0;
	int  double_presses = 0;
	int  inputs_held = 0;
	int  queued_items = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%0t: %s got %0h want %0h", $time, what, got, want);
	endtask

	function automatic logic [31:0] left_ms();
		return (t_elapsed >= t_target) ? 32'd0 : t_target - t_elapsed;
	endfunction

	// window ran out with no second press
	task automatic take_single();
		t_waiting = 1'b0;
		if (t_alarm) begin
			t_alarm = 1'b0;
		end else if (t_run) begin
			t_run = 1'b0;
		end else if (t_target != 32'd0 && !t_set) begin
			t_run = 1'b1;
		end
	endtask

	task automatic advance_timer(input kind_t k, input logic cw);
		res_t r;
		case (k)
		KIND_TICK: begin
			if (t_run && t_elapsed != ALL32)
				t_elapsed = t_elapsed + 32'd1;
			if (t_run && !t_alarm && left_ms() == 32'd0) begin
				t_alarm = 1'b1;
				t_run = 1'b0;
				alarms_raised++;
			end
			if (t_waiting) begin
				if (t_age != ALL16)
					t_age = t_age + 16'd1;
				if (t_age >= cfg_window)
					take_single();
			end
		end
		KIND_START: begin
			if (t_waiting && t_age < cfg_window) begin
				t_waiting = 1'b0;
				t_run = 1'b0;
				t_alarm = 1'b0;
				t_set = 1'b0;
				t_elapsed = 32'd0;
				double_presses++;
			end else begin
				t_waiting = 1'b1;
				t_age = 16'd0;
			end
		end
		KIND_SET: begin
			if (!t_run && !t_alarm)
				t_set = !t_set;
		end
		KIND_STEP: begin
			if (t_set && !t_run && !t_alarm) begin
				if (cw) begin
					if (t_target > ALL32 - {10'd0, cfg_step})
						t_target = ALL32;
					else
						t_target = t_target + {10'd0, cfg_step};
				end else if (t_target >= {10'd0, cfg_step}) begin
					t_target = t_target - {10'd0, cfg_step};
				end
				t_elapsed = 32'd0;
			end
		end
		endcase
		r.running = t_run;
		r.alarm = t_alarm;
		r.setting = t_set;
		r.time_left = left_ms();
		r.target_time = t_target;
		r.press_pending = t_waiting;
		status_due.push_back(r);
	endtask

	// driver: offers queued events, may idle between them
	always @(posedge clk or negedge arst_n) begin
		timer_evt_t nxt;
		int gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_TICK;
			clockwise <= 1'b0;
			send_gap <= 0;
		end else begin
			gap = send_gap;
			if (in_valid && !in_stall) begin
				advance_timer(kind, clockwise);
				gap = send_quiet ? 0 : $urandom_range(0, 10);
			end
			if (!in_valid || !in_stall) begin
				if (gap > 0) begin
					in_valid <= 1'b0;
					send_gap <= gap - 1;
				end else if (pending_events.size() != 0) begin
					nxt = pending_events.pop_front();
					kind <= nxt.kind;
					clockwise <= nxt.cw;
					in_valid <= 1'b1;
					send_gap <= 0;
				end else begin
					in_valid <= 1'b0;
					send_gap <= 0;
				end
			end
		end
	end

	// monitor: checks each result transaction and draws the stall pattern
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		int n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			idle_cycles <= 0;
		end else begin
			n = stall_left;
			if (out_valid && !out_stall) begin
				results_checked++;
				if (status_due.size() == 0) begin
					flag_mismatch("result with nothing expected", target_time, 32'd0);
				end else begin
					want = status_due.pop_front();
					if (running !== want.running)
						flag_mismatch("running", 32'(running), 32'(want.running));
					if (alarm !== want.alarm)
						flag_mismatch("alarm", 32'(alarm), 32'(want.alarm));
					if (setting !== want.setting)
						flag_mismatch("setting", 32'(setting), 32'(want.setting));
					if (time_left !== want.time_left)
						flag_mismatch("time_left", time_left, want.time_left);
					if (target_time !== want.target_time)
						flag_mismatch("target_time", target_time, want.target_time);
					if (press_pending !== want.press_pending)
						flag_mismatch("press_pending", 32'(press_pending),
							32'(want.press_pending));
				end
				n = rcv_quiet ? 0 : $urandom_range(0, 10);
			end
			// long hold-off so the block backs up into its input
			if (hold_request) begin
				n = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				stall_left <= n - 1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= 0;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (in_valid && in_stall)
				inputs_held++;
		end
	end

	initial begin
		while (idle_cycles < STUCK_LIMIT)
			@(posedge clk);
		$display("timed out with %0d transactions outstanding", status_due.size());
		$display("countdown_timer_with_double_press: mismatch");
		$finish;
	end

	task automatic push_evt(input kind_t k, input logic cw = 1'b0);
		pending_events.push_back('{k, cw});
		queued_items++;
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [21:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_WINDOW)
			cfg_window = val[15:0];
		else
			cfg_step = val;
	endtask

	task automatic configure(input logic [15:0] window, input logic [21:0] step);
		write_reg(CFG_WINDOW, {6'd0, window});
		write_reg(CFG_STEP, step);
		@(negedge clk);
	endtask

	// block is idle once nothing is queued, offered or owed
	task automatic settle();
		while (pending_events.size() != 0 || in_valid || status_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic queue_ticks(input int n);
		repeat (n) push_evt(KIND_TICK, 1'($urandom_range(0, 1)));
	endtask

	// mostly well-formed use: adjust target, start, run down, acknowledge
	task automatic queue_session();
		int r = $urandom_range(0, 9);
		int win = int'(cfg_window);
		int pick;
		if (r < 2) begin
			repeat ($urandom_range(1, 8))
				push_evt(kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
		end else begin
			push_evt(KIND_SET, 1'($urandom_range(0, 1)));
			repeat ($urandom_range(1, 6))
				push_evt(KIND_STEP, 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) != 0)
				push_evt(KIND_SET);
			push_evt(KIND_START);
			queue_ticks(win + 1);
			repeat ($urandom_range(0, 40)) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					push_evt(KIND_START);
				else if (pick == 1)
					push_evt(KIND_SET);
				else if (pick == 2)
					push_evt(KIND_STEP, 1'($urandom_range(0, 1)));
				else
					push_evt(KIND_TICK, 1'($urandom_range(0, 1)));
			end
			if (r == 9) begin
				push_evt(KIND_START);
				queue_ticks($urandom_range(0, win));
				push_evt(KIND_START);
			end
			push_evt(KIND_START);
			queue_ticks(win + 1);
		end
	endtask

	task automatic random_phase(input logic [15:0] window, input logic [21:0] step,
			input bit quiet_tx, input bit quiet_rx, input bit squeeze);
		int start_count;
		configure(window, step);
		send_quiet = quiet_tx;
		rcv_quiet = quiet_rx;
		start_count = queued_items;
		while (queued_items - start_count < RANDOM_PER_PHASE)
			queue_session();
		if (squeeze)
			hold_request = 1'b1;
		settle();
	endtask

	initial begin
		t_elapsed = '0;
		t_target = '0;
		t_run = 1'b0;
		t_alarm = 1'b0;
		t_set = 1'b0;
		t_waiting = 1'b0;
		t_age = '0;
		cfg_window = WINDOW_RST;
		cfg_step = STEP_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults: set mode, steps at zero and up, ignored steps, double press
		push_evt(KIND_TICK);
		push_evt(KIND_SET);
		push_evt(KIND_STEP, 1'b0);
		push_evt(KIND_STEP, 1'b1);
		push_evt(KIND_STEP, 1'b1);
		push_evt(KIND_STEP, 1'b0);
		push_evt(KIND_SET);
		push_evt(KIND_STEP, 1'b1);
		push_evt(KIND_START, 1'b1);
		push_evt(KIND_START);
		settle();

		// short window: start, run to alarm, ignored presses, clear, restart into alarm, clear
		configure(16'd2, 22'd3);
		push_evt(KIND_SET);
		push_evt(KIND_STEP, 1'b1);
		push_evt(KIND_STEP, 1'b1);
		push_evt(KIND_SET);
		push_evt(KIND_START);
		queue_ticks(9);
		push_evt(KIND_SET);
		push_evt(KIND_STEP, 1'b1);
		push_evt(KIND_START);
		queue_ticks(2);
		push_evt(KIND_START);
		queue_ticks(4);
		push_evt(KIND_START);
		queue_ticks(3);
		settle();

		random_phase(16'd1, 22'd1, 1'b1, 1'b0, 1'b1);
		random_phase(16'd3, 22'd2, 1'b0, 1'b0, 1'b0);
		random_phase(16'd0, 22'd0, 1'b0, 1'b1, 1'b0);
		random_phase(16'd5, 22'd4, 1'b1, 1'b1, 1'b0);

		// widest step: large target moves up and down
		configure(16'd7, 22'h3F_FFFF);
		send_quiet = 1'b0;
		rcv_quiet = 1'b0;
		push_evt(KIND_SET);
		repeat (12) push_evt(KIND_STEP, 1'b1);
		repeat (3) push_evt(KIND_STEP, 1'b0);
		push_evt(KIND_SET);
		push_evt(KIND_START);
		queue_ticks(13);
		push_evt(KIND_START);
		queue_ticks(8);
		settle();

		// widest window: a late second press still counts as double
		configure(16'hFFFF, 22'd1);
		send_quiet = 1'b1;
		rcv_quiet = 1'b1;
		push_evt(KIND_START);
		queue_ticks(20);
		push_evt(KIND_START);
		push_evt(KIND_START);
		queue_ticks(5);
		settle();
		repeat (6) @(posedge clk);

		$display("checked %0d result transactions from %0d queued events", results_checked,
			queued_items);
		$display("%0d alarms, %0d double presses, input held back on %0d cycles",
			alarms_raised, double_presses, inputs_held);
		if (mismatches == 0)
			$display("countdown_timer_with_double_press: match");
		else
			$display("countdown_timer_with_double_press: mismatch");
		$finish;
	end

endmodule
